>>> rtl/core/clsr_pkg.sv
`timescale 1ns / 1ps

package clsr_pkg;

  // Widths of the loop arithmetic.
  localparam int SIG_W  = 32;  // Q16.16 signals
  localparam int COEF_W = 16;  // Q4.12 coefficients
  localparam int PROD_W = SIG_W + COEF_W;
  localparam int ACC_W  = 52;  // sum of up to five products with headroom
  localparam int FRAC_SHIFT = 12;
  localparam int LIM_W  = 31;
  localparam int CNT_W  = 16;

  // Configuration port geometry: 64-bit data, registers on 8-byte strides.
  localparam int PADDR_W = 6;
  localparam int PDATA_W = 64;

  typedef enum logic [2:0] {
    REG_SETPOINT    = 3'd0,
    REG_ERROR_LIMIT = 3'd1,
    REG_CTRL_NUM    = 3'd2,
    REG_CTRL_DEN    = 3'd3,
    REG_PLANT_NUM   = 3'd4,
    REG_PLANT_DEN   = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLANT,
    ST_PSCALE,
    ST_ERR,
    ST_CTRL,
    ST_CSCALE,
    ST_UPD
  } state_t;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic clear;  // zero the accumulator
    logic vld;    // a product term is presented this cycle
    logic sub;    // the term is subtracted rather than added
  } mac_ctl_t;

  typedef struct packed {
    logic [SIG_W-1:0] val;
    logic             ovf;
  } sat_t;

  // Round half up, floor-shift by the coefficient fraction, saturate to 32 bits.
  function automatic sat_t rescale(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] v;
    logic signed [ACC_W-1:0] q;
    sat_t r;
    v = acc + ACC_W'(2048);
    q = v >>> FRAC_SHIFT;
    if (q[ACC_W-1:SIG_W-1] == '0 || q[ACC_W-1:SIG_W-1] == '1) begin
      r.val = q[SIG_W-1:0];
      r.ovf = 1'b0;
    end else begin
      r.ovf = 1'b1;
      r.val = q[ACC_W-1] ? {1'b1, {(SIG_W-1){1'b0}}} : {1'b0, {(SIG_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Saturate a 33-bit difference to 32 bits.
  function automatic sat_t sat33(input logic [SIG_W:0] d);
    sat_t r;
    if (d[SIG_W] == d[SIG_W-1]) begin
      r.val = d[SIG_W-1:0];
      r.ovf = 1'b0;
    end else begin
      r.ovf = 1'b1;
      r.val = d[SIG_W] ? {1'b1, {(SIG_W-1){1'b0}}} : {1'b0, {(SIG_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

>>> rtl/core/clsr_if.sv
`timescale 1ns / 1ps

// Tick channel: one request advances the loop by one step.
interface clsr_tick_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

// Result channel: one request per step.
interface clsr_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] plant_output;
  logic [30:0] error_sum;
  logic        limit_hit;
  logic        last_of_run;

  modport source (output valid, output plant_output, output error_sum,
                  output limit_hit, output last_of_run, input ready);
  modport sink (input valid, input plant_output, input error_sum,
                input limit_hit, input last_of_run, output ready);
endinterface

>>> rtl/core/clsr_mac.sv
`timescale 1ns / 1ps

// Shared multiply-accumulate unit: registered product, then accumulation.
module clsr_mac (
  input  logic                                   clk,
  input  logic                                   rst,
  input  clsr_pkg::mac_ctl_t                     ctl,
  input  logic signed [clsr_pkg::COEF_W-1:0]     coef,
  input  logic signed [clsr_pkg::SIG_W-1:0]      data,
  output logic signed [clsr_pkg::ACC_W-1:0]      acc
);

  logic signed [clsr_pkg::PROD_W-1:0] prod;
  logic                               prod_vld;
  logic                               prod_sub;
  logic signed [clsr_pkg::ACC_W-1:0]  prod_ext;

  assign prod_ext = {{(clsr_pkg::ACC_W-clsr_pkg::PROD_W){prod[clsr_pkg::PROD_W-1]}}, prod};

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    prod     <= coef * data;
    prod_sub <= ctl.sub;
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= prod_sub ? acc - prod_ext : acc + prod_ext;
    end
  end

endmodule

>>> rtl/core/closed_loop_step_response.sv
`timescale 1ns / 1ps

// Closed-loop step response engine.
// Each request on the tick channel advances a plant/controller loop of two
// second-order difference equations by one step, and produces exactly one
// request on the result channel: the plant output before the step, the
// running absolute-error sum (clipped at error_limit), a sticky limit or
// overflow flag, and a last-of-run mark every RUN_LENGTH steps.
// A tick with restart set clears the loop state before its step.
// Coefficients, setpoint and error limit are written over the APB-style port,
// by the user only while the engine is idle; the block does not enforce this.
// pready is always high and reads return the value. One step uses the single
// shared 16x32 multiplier for nine products (four plant, five controller
// terms) plus rescaling and update states. The tick channel is ready only in
// the idle state, so no new tick is taken until the step in progress has made
// its update. A finished result sits in an output register, so the next tick
// is taken while the result waits; if the receiver stalls, the following step
// finishes its arithmetic and then holds until the output register frees.
// Reset restores configuration defaults and clears loop state and result valid.
module closed_loop_step_response #(
  parameter int RUN_LENGTH = 20
) (
  input  logic                              clk,
  input  logic                              rst,
  clsr_tick_if.sink                         tick,
  clsr_result_if.source                     result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [clsr_pkg::PADDR_W-1:0]      paddr,
  input  logic [clsr_pkg::PDATA_W-1:0]      pwdata,
  output logic [clsr_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  localparam int SW = clsr_pkg::SIG_W;

  // Configuration registers.
  logic [31:0]            setpoint;
  logic [30:0]            error_limit;
  logic [47:0]            ctrl_num_coeffs;
  logic [31:0]            ctrl_den_coeffs;
  logic [31:0]            plant_num_coeffs;
  logic [31:0]            plant_den_coeffs;
  logic                   cfg_wr;
  clsr_pkg::reg_idx_t     cfg_idx;

  // Loop state.
  logic signed [SW-1:0]   y1, y2, c1, c2, e1, e2;
  logic [30:0]            err_accum;
  logic                   ovf_flag;
  logic [clsr_pkg::CNT_W-1:0] step_count;

  // Per-step working registers.
  logic signed [SW-1:0]   yp, e_cur, u;
  logic                   ovf_step;
  logic [SW:0]            diff;
  logic [33:0]            sum;
  logic                   sum_gt;

  // Sequencer.
  clsr_pkg::state_t       state, state_next;
  logic [2:0]             cnt, cnt_next;

  // Shared unit.
  clsr_pkg::mac_ctl_t                     mac_ctl;
  logic signed [clsr_pkg::COEF_W-1:0]     mac_coef;
  logic signed [SW-1:0]                   mac_data;
  logic signed [clsr_pkg::ACC_W-1:0]      acc;

  clsr_pkg::sat_t         acc_sat;
  clsr_pkg::sat_t         e_sat;
  logic                   tick_acc;
  logic                   slot_free;
  logic                   flag_new;
  logic                   last;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = clsr_pkg::reg_idx_t'(paddr[clsr_pkg::PADDR_W-1:3]);

  always_comb begin
    case (cfg_idx)
      clsr_pkg::REG_SETPOINT:    prdata = {32'd0, setpoint};
      clsr_pkg::REG_ERROR_LIMIT: prdata = {33'd0, error_limit};
      clsr_pkg::REG_CTRL_NUM:    prdata = {16'd0, ctrl_num_coeffs};
      clsr_pkg::REG_CTRL_DEN:    prdata = {32'd0, ctrl_den_coeffs};
      clsr_pkg::REG_PLANT_NUM:   prdata = {32'd0, plant_num_coeffs};
      clsr_pkg::REG_PLANT_DEN:   prdata = {32'd0, plant_den_coeffs};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint         <= 32'd65536;
      error_limit      <= 31'd655360000;
      ctrl_num_coeffs  <= 48'd4096;
      ctrl_den_coeffs  <= 32'd61440;
      plant_num_coeffs <= 32'd268439552;
      plant_den_coeffs <= 32'd4281594266;
    end else if (cfg_wr) begin
      case (cfg_idx)
        clsr_pkg::REG_SETPOINT:    setpoint         <= pwdata[31:0];
        clsr_pkg::REG_ERROR_LIMIT: error_limit      <= pwdata[30:0];
        clsr_pkg::REG_CTRL_NUM:    ctrl_num_coeffs  <= pwdata[47:0];
        clsr_pkg::REG_CTRL_DEN:    ctrl_den_coeffs  <= pwdata[31:0];
        clsr_pkg::REG_PLANT_NUM:   plant_num_coeffs <= pwdata[31:0];
        clsr_pkg::REG_PLANT_DEN:   plant_den_coeffs <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  assign tick.ready = (state == clsr_pkg::ST_IDLE);
  assign tick_acc   = tick.valid & tick.ready;
  assign slot_free  = ~result.valid | result.ready;

  // Sequencer: state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= clsr_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Sequencer: next state and the operands fed to the shared unit. The plant
  // takes four terms and a drain step, the controller five terms and a drain.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    mac_ctl    = '0;
    mac_coef   = '0;
    mac_data   = '0;
    case (state)
      clsr_pkg::ST_IDLE: begin
        if (tick.valid) begin
          state_next = clsr_pkg::ST_PLANT;
          cnt_next   = '0;
        end
      end
      clsr_pkg::ST_PLANT: begin
        mac_ctl.clear = (cnt == 3'd0);
        mac_ctl.vld   = (cnt != 3'd4);
        case (cnt)
          3'd0: begin
            mac_coef = plant_num_coeffs[15:0];
            mac_data = c1;
          end
          3'd1: begin
            mac_coef = plant_num_coeffs[31:16];
            mac_data = c2;
          end
          3'd2: begin
            mac_coef    = plant_den_coeffs[15:0];
            mac_data    = y1;
            mac_ctl.sub = 1'b1;
          end
          3'd3: begin
            mac_coef    = plant_den_coeffs[31:16];
            mac_data    = y2;
            mac_ctl.sub = 1'b1;
          end
          default: ;
        endcase
        if (cnt == 3'd4) begin
          state_next = clsr_pkg::ST_PSCALE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 3'd1;
        end
      end
      clsr_pkg::ST_PSCALE: state_next = clsr_pkg::ST_ERR;
      clsr_pkg::ST_ERR: begin
        state_next = clsr_pkg::ST_CTRL;
        cnt_next   = '0;
      end
      clsr_pkg::ST_CTRL: begin
        mac_ctl.clear = (cnt == 3'd0);
        mac_ctl.vld   = (cnt != 3'd5);
        case (cnt)
          3'd0: begin
            mac_coef = ctrl_num_coeffs[15:0];
            mac_data = e_cur;
          end
          3'd1: begin
            mac_coef = ctrl_num_coeffs[31:16];
            mac_data = e1;
          end
          3'd2: begin
            mac_coef = ctrl_num_coeffs[47:32];
            mac_data = e2;
          end
          3'd3: begin
            mac_coef    = ctrl_den_coeffs[15:0];
            mac_data    = c1;
            mac_ctl.sub = 1'b1;
          end
          3'd4: begin
            mac_coef    = ctrl_den_coeffs[31:16];
            mac_data    = c2;
            mac_ctl.sub = 1'b1;
          end
          default: ;
        endcase
        if (cnt == 3'd5) begin
          state_next = clsr_pkg::ST_CSCALE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 3'd1;
        end
      end
      clsr_pkg::ST_CSCALE: state_next = clsr_pkg::ST_UPD;
      clsr_pkg::ST_UPD: begin
        if (slot_free) begin
          state_next = clsr_pkg::ST_IDLE;
        end
      end
      default: state_next = clsr_pkg::ST_IDLE;
    endcase
  end

  clsr_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .coef (mac_coef),
    .data (mac_data),
    .acc  (acc)
  );

  assign acc_sat  = clsr_pkg::rescale(acc);
  assign e_sat    = clsr_pkg::sat33({setpoint[31], setpoint} - {yp[SW-1], yp});
  assign flag_new = ovf_flag | sum_gt | ovf_step;
  assign last     = (step_count == clsr_pkg::CNT_W'(RUN_LENGTH - 1));

  // Loop state: cleared by reset or by a restart tick, advanced once a step
  // has its controller output and the output register is free.
  always_ff @(posedge clk) begin
    if (rst || (tick_acc && tick.restart)) begin
      y1         <= '0;
      y2         <= '0;
      c1         <= '0;
      c2         <= '0;
      e1         <= '0;
      e2         <= '0;
      err_accum  <= '0;
      ovf_flag   <= 1'b0;
      step_count <= '0;
    end else if (state == clsr_pkg::ST_UPD && slot_free) begin
      y2         <= y1;
      y1         <= yp;
      c2         <= c1;
      c1         <= u;
      e2         <= e1;
      e1         <= e_cur;
      ovf_flag   <= flag_new;
      err_accum  <= flag_new ? error_limit : sum[30:0];
      step_count <= last ? '0 : step_count + clsr_pkg::CNT_W'(1);
    end
  end

  // Working registers of one step. The error-sum term uses the plant output
  // from before the step, so it runs alongside the controller products.
  always_ff @(posedge clk) begin
    if (tick_acc) begin
      ovf_step <= 1'b0;
    end
    case (state)
      clsr_pkg::ST_PSCALE: begin
        yp       <= acc_sat.val;
        ovf_step <= ovf_step | acc_sat.ovf;
        diff     <= {setpoint[31], setpoint} - {y1[SW-1], y1};
      end
      clsr_pkg::ST_ERR: begin
        e_cur    <= e_sat.val;
        ovf_step <= ovf_step | e_sat.ovf;
        sum      <= diff[SW] ? {3'd0, err_accum} - {diff[SW], diff}
                             : {3'd0, err_accum} + {diff[SW], diff};
      end
      clsr_pkg::ST_CTRL: begin
        if (cnt == 3'd0) begin
          sum_gt <= (sum > {3'd0, error_limit});
        end
      end
      clsr_pkg::ST_CSCALE: begin
        u        <= acc_sat.val;
        ovf_step <= ovf_step | acc_sat.ovf;
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == clsr_pkg::ST_UPD && slot_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == clsr_pkg::ST_UPD && slot_free) begin
      result.plant_output <= y1;
      result.error_sum    <= flag_new ? error_limit : sum[30:0];
      result.limit_hit    <= flag_new;
      result.last_of_run  <= last;
    end
  end

`ifndef SYNTHESIS
  // A result only appears as a step completes its update.
  assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state) == clsr_pkg::ST_UPD)
    else $error("result raised outside of the update state");

  // An accepted tick starts the plant products with the first term.
  assert property (@(posedge clk) disable iff (rst)
    tick_acc |=> (state == clsr_pkg::ST_PLANT && cnt == 3'd0))
    else $error("accepted tick did not start the plant sequence");

  // A completed update always leaves a pending result and returns to idle.
  assert property (@(posedge clk) disable iff (rst)
    (state == clsr_pkg::ST_UPD && slot_free) |=>
      (state == clsr_pkg::ST_IDLE && result.valid))
    else $error("update did not publish a result");

  // The term counter stays within the plant equation's length.
  assert property (@(posedge clk) disable iff (rst)
    (state == clsr_pkg::ST_PLANT) |-> (cnt <= 3'd4))
    else $error("plant term counter out of range");
`endif

endmodule

>>> verif/tb_closed_loop_step_response.sv
`timescale 1ns / 1ps

module tb_closed_loop_step_response;

  localparam int RUN_LENGTH  = 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN       = 32;

  // A register index that decodes to nothing; writes to it must be dropped.
  localparam logic [2:0] SPARE_IDX = 3'd6;

  // Flavors of loop configuration used by the random phases.
  typedef enum int {
    CFG_STABLE,
    CFG_TIGHT,
    CFG_RANDOM
  } loop_cfg_t;

  // One result request as the block should present it.
  typedef struct packed {
    logic [31:0] plant_output;
    logic [30:0] error_sum;
    logic        limit_hit;
    logic        last_of_run;
  } step_result_t;

  logic clk = 1'b0;
  logic rst;

  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [clsr_pkg::PADDR_W-1:0] paddr;
  logic [clsr_pkg::PDATA_W-1:0] pwdata;
  logic [clsr_pkg::PDATA_W-1:0] prdata;
  logic                         pready;

  clsr_tick_if   tick_ch ();
  clsr_result_if result_ch ();

  closed_loop_step_response #(
    .RUN_LENGTH(RUN_LENGTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .tick(tick_ch),
    .result(result_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor state. The configuration copy is updated at the same edge
  // at which the block takes a register write; the loop state advances
  // once for every tick request the block accepts.
  // ---------------------------------------------------------------------
  logic signed [31:0] cfg_setpoint;
  logic [30:0]        cfg_limit;
  logic [47:0]        cfg_ctrl_num;
  logic [31:0]        cfg_ctrl_den;
  logic [31:0]        cfg_plant_num;
  logic [31:0]        cfg_plant_den;

  logic signed [31:0] loop_y1, loop_y2;  // past plant outputs
  logic signed [31:0] loop_u1, loop_u2;  // past controller outputs
  logic signed [31:0] loop_e1, loop_e2;  // past errors
  logic [30:0]        abs_err_total;
  logic               limit_latched;
  logic [15:0]        run_step;
  logic               step_overflow;     // set by any saturation within a step

  // Stimulus and expectation stores.
  bit           pending_ticks[$];
  step_result_t due_results[$];

  // Traffic shaping, set by the sequencing block between phases.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_on        = 1'b0;

  logic tick_taken = 1'b0;

  int cycles         = 0;
  int mismatches     = 0;
  int steps_checked  = 0;
  int restarts_taken = 0;
  int limit_results  = 0;
  int run_ends       = 0;
  int phases_run     = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  function automatic longint q412(input logic [47:0] word, input int k);
    logic signed [15:0] c;
    c = word[16*k +: 16];
    return longint'(c);
  endfunction

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) begin
      step_overflow = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      step_overflow = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Round half up on the Q.28 sum, then drop the 12 coefficient fraction bits.
  function automatic logic signed [31:0] round_q12(input longint acc);
    longint q;
    q = (acc + 64'sd2048) >>> 12;
    return clip32(q);
  endfunction

  function automatic void clear_loop();
    loop_y1 = '0;
    loop_y2 = '0;
    loop_u1 = '0;
    loop_u2 = '0;
    loop_e1 = '0;
    loop_e2 = '0;
    abs_err_total = '0;
    limit_latched = 1'b0;
    run_step = '0;
  endfunction

  function automatic step_result_t advance_loop(input logic restart);
    longint sp, lim, prev, diff, sum;
    logic signed [31:0] yp, e, u;
    logic last;
    step_result_t r;
    if (restart)
      clear_loop();
    step_overflow = 1'b0;
    sp   = longint'(cfg_setpoint);
    lim  = longint'(cfg_limit);
    prev = longint'(loop_y1);

    yp = round_q12(q412(48'(cfg_plant_num), 0) * longint'(loop_u1)
                 + q412(48'(cfg_plant_num), 1) * longint'(loop_u2)
                 - q412(48'(cfg_plant_den), 0) * longint'(loop_y1)
                 - q412(48'(cfg_plant_den), 1) * longint'(loop_y2));
    e = clip32(sp - longint'(yp));
    u = round_q12(q412(cfg_ctrl_num, 0) * longint'(e)
                + q412(cfg_ctrl_num, 1) * longint'(loop_e1)
                + q412(cfg_ctrl_num, 2) * longint'(loop_e2)
                - q412(48'(cfg_ctrl_den), 0) * longint'(loop_u1)
                - q412(48'(cfg_ctrl_den), 1) * longint'(loop_u2));

    loop_e2 = loop_e1;
    loop_e1 = e;
    loop_u2 = loop_u1;
    loop_u1 = u;
    loop_y2 = loop_y1;
    loop_y1 = yp;

    // The error sum uses the plant output as it stood before this step.
    diff = sp - prev;
    if (diff < 0)
      diff = -diff;
    sum = longint'(abs_err_total) + diff;
    if (sum > lim || step_overflow)
      limit_latched = 1'b1;
    abs_err_total = limit_latched ? cfg_limit : sum[30:0];

    last = (run_step == 16'(RUN_LENGTH - 1));
    run_step = last ? 16'd0 : run_step + 16'd1;

    r.plant_output = prev[31:0];
    r.error_sum    = abs_err_total;
    r.limit_hit    = limit_latched;
    r.last_of_run  = last;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Driver. Inputs change only at the falling edge. A tick request stays
  // up until the block takes it; a new one is offered only once the
  // previous one was seen accepted at the rising edge.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      tick_ch.valid   <= 1'b0;
      tick_ch.restart <= 1'b0;
      result_ch.ready <= 1'b0;
    end else begin
      if (!tick_ch.valid || tick_taken) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          tick_ch.valid   <= 1'b1;
          tick_ch.restart <= pending_ticks[0];
        end else begin
          // While idle the restart line carries noise the block must ignore.
          tick_ch.valid   <= 1'b0;
          tick_ch.restart <= 1'($urandom_range(1));
        end
      end
      result_ch.ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Monitor. While reset is held the predictor loop is cleared, as the
  // block's is. At each rising edge after that an accepted tick request
  // advances the predictor, and an accepted result request is checked
  // against the oldest expectation. The cycle limit is enforced here too.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    step_result_t want;
    tick_taken <= !rst && tick_ch.valid && tick_ch.ready;
    if (rst) begin
      clear_loop();
    end else begin
      cycles++;
      if (tick_ch.valid && tick_ch.ready) begin
        if (tick_ch.restart)
          restarts_taken++;
        due_results.push_back(advance_loop(tick_ch.restart));
        void'(pending_ticks.pop_front());
      end
      if (result_ch.valid && result_ch.ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("result request with no step outstanding");
        end else begin
          want = due_results.pop_front();
          steps_checked++;
          if (want.limit_hit)
            limit_results++;
          if (want.last_of_run)
            run_ends++;
          if (result_ch.plant_output !== want.plant_output ||
              result_ch.error_sum !== want.error_sum ||
              result_ch.limit_hit !== want.limit_hit ||
              result_ch.last_of_run !== want.last_of_run)
            report_mismatch($sformatf(
              "step %0d: y=%h sum=%h hit=%b last=%b, expected y=%h sum=%h hit=%b last=%b",
              steps_checked, result_ch.plant_output, result_ch.error_sum,
              result_ch.limit_hit, result_ch.last_of_run, want.plant_output,
              want.error_sum, want.limit_hit, want.last_of_run));
        end
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles with %0d ticks queued and %0d results due.",
                 cycles, pending_ticks.size(), due_results.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequencing helpers.
  // ---------------------------------------------------------------------

  // A register write: setup cycle, then access cycle. The block takes the
  // data at the rising edge where psel, penable, pwrite and pready are high,
  // and the predictor copy follows at that same edge.
  task automatic apb_write(input logic [2:0] idx, input logic [63:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= clsr_pkg::PADDR_W'({idx, 3'b000});
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      clsr_pkg::REG_SETPOINT:    cfg_setpoint  = data[31:0];
      clsr_pkg::REG_ERROR_LIMIT: cfg_limit     = data[30:0];
      clsr_pkg::REG_CTRL_NUM:    cfg_ctrl_num  = data[47:0];
      clsr_pkg::REG_CTRL_DEN:    cfg_ctrl_den  = data[31:0];
      clsr_pkg::REG_PLANT_NUM:   cfg_plant_num = data[31:0];
      clsr_pkg::REG_PLANT_DEN:   cfg_plant_den = data[31:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Registers may only change while the loop is idle: every tick handed
  // over and every result request received. Each tick yields exactly one
  // result, so an empty expectation store means the engine is at rest.
  task automatic wait_drained();
    do @(negedge clk); while (pending_ticks.size() != 0 || due_results.size() != 0);
  endtask

  task automatic program_all(input logic [63:0] sp, input logic [63:0] lim,
                             input logic [63:0] cn, input logic [63:0] cd,
                             input logic [63:0] pn, input logic [63:0] pd);
    apb_write(clsr_pkg::REG_SETPOINT, sp);
    apb_write(clsr_pkg::REG_ERROR_LIMIT, lim);
    apb_write(clsr_pkg::REG_CTRL_NUM, cn);
    apb_write(clsr_pkg::REG_CTRL_DEN, cd);
    apb_write(clsr_pkg::REG_PLANT_NUM, pn);
    apb_write(clsr_pkg::REG_PLANT_DEN, pd);
  endtask

  // Pick register values for a random phase. The stable flavor keeps the
  // gains small so runs stay out of saturation for a while and the error
  // sum builds up step by step; the tight flavor adds a small error limit
  // so clipping happens mid-run; the random flavor writes arbitrary words,
  // including bits above each register's width.
  task automatic program_loop(input loop_cfg_t kind);
    logic [63:0] sp, lim;
    if (kind == CFG_RANDOM) begin
      program_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
      apb_write(SPARE_IDX, {$urandom, $urandom});
    end else begin
      sp = 64'($urandom_range(32'h0010_0000));
      if ($urandom_range(1))
        sp = -sp;
      lim = (kind == CFG_TIGHT) ? 64'($urandom_range(32'h0020_0000))
                                : 64'($urandom_range(32'h7FFF_FFFF, 32'h0100_0000));
      program_all(sp, lim,
                  64'({16'($urandom_range(256)), 16'(-$urandom_range(1024)),
                       16'($urandom_range(2048))}),
                  64'({16'($urandom_range(512)), 16'(-$urandom_range(4096, 2048))}),
                  64'({16'($urandom_range(1024)), 16'($urandom_range(2048))}),
                  64'({16'($urandom_range(1024)), 16'(-$urandom_range(3072, 1024))}));
    end
  endtask

  // Items are queued just after a rising edge, where the driver never looks
  // at the queue, and only while nothing is in flight.
  task automatic queue_tick(input bit restart);
    pending_ticks.push_back(restart);
  endtask

  task automatic run_phase(input loop_cfg_t kind, input int send_pct, input int recv_pct,
                           input bit squeeze, input int count);
    wait_drained();
    program_loop(kind);
    @(posedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (squeeze) begin
      // The receiver holds off for a long stretch in a process of its own.
      // The sender keeps offering ticks, so one result sits in the output
      // register, the next step finishes and waits, and the tick channel
      // stops taking requests until the hold is released.
      fork
        begin
          hold_on = 1'b1;
          repeat (LONG_HOLD) @(posedge clk);
          hold_on = 1'b0;
        end
      join_none
    end
    // Mostly long runs that cross several run boundaries, with the odd
    // restart dropped in at a random point.
    queue_tick(1'b1);
    for (int i = 1; i < count; i++)
      queue_tick($urandom_range(29) == 0);
    phases_run++;
  endtask

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin
    rst     = 1'b1;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;

    // Reset values of the registers.
    cfg_setpoint  = 32'sd65536;
    cfg_limit     = 31'd655360000;
    cfg_ctrl_num  = 48'd4096;
    cfg_ctrl_den  = 32'd61440;
    cfg_plant_num = 32'd268439552;
    cfg_plant_den = 32'd4281594266;

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed: the reset configuration, one full run straight out of reset
    // with no restart and one step into the next, so the cleared loop after
    // reset, the last-of-run mark and the wrap of the step counter are seen.
    @(posedge clk);
    for (int i = 0; i < 21; i++)
      queue_tick(1'b0);
    phases_run++;

    // Directed: most negative setpoint and coefficients with a zero error
    // limit. The very first error already exceeds the limit, so the sum is
    // pinned at zero and the flag sticks across the following steps.
    wait_drained();
    program_all(64'h0000_0000_8000_0000, 64'd0, 64'h0000_8000_8000_8000,
                64'h0000_0000_8000_8000, 64'h0000_0000_8000_8000,
                64'h0000_0000_8000_8000);
    @(posedge clk);
    queue_tick(1'b1);
    queue_tick(1'b0);
    queue_tick(1'b0);
    phases_run++;

    // Directed: most positive setpoint and coefficients with the largest
    // limit. The products drive the equations into saturation, which must
    // raise the flag through arithmetic overflow rather than the limit.
    // The restart also shows that the flag from before is cleared.
    wait_drained();
    program_all(64'h0000_0000_7FFF_FFFF, 64'h0000_0000_7FFF_FFFF,
                64'h0000_7FFF_7FFF_7FFF, 64'h0000_0000_7FFF_7FFF,
                64'h0000_0000_7FFF_7FFF, 64'h0000_0000_7FFF_7FFF);
    @(posedge clk);
    queue_tick(1'b1);
    queue_tick(1'b0);
    phases_run++;

    // Random phases, each with its own register setting and traffic shape.
    run_phase(CFG_STABLE, 0, 0, 1'b0, 80);
    run_phase(CFG_STABLE, 72, 0, 1'b0, 80);
    run_phase(CFG_RANDOM, 0, 72, 1'b0, 80);
    run_phase(CFG_TIGHT, 34, 34, 1'b0, 80);
    run_phase(CFG_STABLE, 0, 0, 1'b1, 80);

    // Let everything drain, then give the engine time to show any stray
    // result request it should not produce.
    wait_drained();
    repeat (DRAIN) @(negedge clk);

    $display("Run covered %0d checked steps over %0d phases, %0d restarts, %0d run ends.",
             steps_checked, phases_run, restarts_taken, run_ends);
    $display("Results with the limit flag set: %0d; mismatches reported: %0d.",
             limit_results, mismatches);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
